// File: sv/float_reciprocal_table_interp_unit_macros.svh
// assertion macros shared by the checker
`ifndef FLOAT_RECIPROCAL_TABLE_INTERP_UNIT_MACROS_SVH
`define FLOAT_RECIPROCAL_TABLE_INTERP_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define FRTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frti assertion failed");

// next-cycle implication, disabled while reset is held
`define FRTI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frti assertion failed");

`endif

// File: sv/frti_pkg.sv
package frti_pkg;

  localparam int IDX_W     = 11;
  localparam int LOW_W     = 12;
  localparam int SLOPE_W   = 13;
  localparam int FRAC_W    = 23;
  localparam int EXP_W     = 8;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = SLOPE_W + LOW_W;
  localparam int ROM_DEPTH = 1 << IDX_W;

  localparam logic [EXP_W-1:0] EXP_LIMIT = 8'd253;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [FRAC_W-1:0]  icept;
  } rom_entry_t;

endpackage

// File: sv/float_reciprocal_table_interp_unit.sv
// Approximate single-precision reciprocal. One operand per cycle is accepted
// on the in_ stream while out_tready stays high; the result leaves on the out_
// stream after both register stages: the first is the registered read
// of the 2048-entry slope/intercept ROM, the second holds the result after one
// 13x12 multiply and subtract. Back-pressure stalls both stages; an empty
// stage is refilled even while the one after it is stalled. The fraction is
// the intercept minus the scaled slope correction, wrapped to 23 bits; the
// exponent is 253 minus the operand exponent, or 0 for exponents above 253;
// the sign passes through. Zero, infinity, NaN and denormals get no special
// treatment. Nothing needs initializing after reset.
module float_reciprocal_table_interp_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [frti_pkg::WORD_W-1:0] in_tdata,   // operand[31:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [frti_pkg::WORD_W-1:0] out_tdata   // reciprocal[31:0]
);
  import frti_pkg::*;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               s1_sign_r;
  logic [EXP_W-1:0]   s1_exp_r;
  logic [LOW_W-1:0]   s1_low_r;
  rom_entry_t         s1_rom_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [WORD_W-1:0]  out_data_r;
  logic [WORD_W-1:0]  out_data_nxt;
  logic               adv2;
  logic               adv1;
  logic [PROD_W-1:0]  prod;
  logic [FRAC_W-1:0]  frac;
  logic [EXP_W-1:0]   exp_res;

  assign adv2      = !out_valid_r || out_tready;
  assign adv1      = !s1_valid_r || adv2;
  assign in_tready = adv1;

  frti_rom u_rom (
    .clk       (clk),
    .rd_en     (adv1),
    .rd_idx    (in_tdata[LOW_W +: IDX_W]),
    .rd_data_r (s1_rom_r)
  );

  always_comb begin
    prod          = PROD_W'(s1_rom_r.slope) * PROD_W'(s1_low_r);
    frac          = s1_rom_r.icept - FRAC_W'(prod[PROD_W-1:LOW_W]);
    exp_res       = (s1_exp_r > EXP_LIMIT) ? '0 : EXP_LIMIT - s1_exp_r;
    out_data_nxt  = {s1_sign_r, exp_res, frac};
    s1_valid_nxt  = adv1 ? in_tvalid : s1_valid_r;
    out_valid_nxt = adv2 ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_sign_r <= in_tdata[WORD_W-1];
      s1_exp_r  <= in_tdata[FRAC_W +: EXP_W];
      s1_low_r  <= in_tdata[LOW_W-1:0];
    end
    if (adv2) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/frti_rom.sv
module frti_rom (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [frti_pkg::IDX_W-1:0] rd_idx,
  output frti_pkg::rom_entry_t       rd_data_r
);
  import frti_pkg::*;

  rom_entry_t rom_w [ROM_DEPTH];

  // slope = floor(2^33 (2a+1)^2 / (a^2 (a+1)^2)), icept = floor(2^33 (2a+1)(2a+3) / (a (a+1)^2))
  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_entry
    localparam logic [63:0] A          = 64'(ROM_DEPTH + k);
    localparam logic [63:0] S_NUM      = (2 * A + 1) * (2 * A + 1);
    localparam logic [63:0] S_DEN      = A * A * (A + 1) * (A + 1);
    localparam logic [63:0] I_NUM      = (2 * A + 1) * (2 * A + 3);
    localparam logic [63:0] I_DEN      = A * (A + 1) * (A + 1);
    localparam logic [63:0] SLOPE_FULL = (S_NUM << 33) / S_DEN;
    localparam logic [63:0] ICEPT_FULL = (I_NUM << 33) / I_DEN;
    assign rom_w[k] = '{slope: SLOPE_FULL[SLOPE_W-1:0], icept: ICEPT_FULL[FRAC_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_w[rd_idx];
    end
  end

endmodule

// File: sv/frti_checker.sv
`include "float_reciprocal_table_interp_unit_macros.svh"

module frti_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [frti_pkg::WORD_W-1:0] out_tdata
);
  import frti_pkg::*;

  logic in_xact;
  logic out_stall;
  logic exp_top;
  logic exp_big;

  assign in_xact   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign exp_top   = out_tdata[FRAC_W +: EXP_W] == 8'hff;
  assign exp_big   = out_tdata[FRAC_W +: EXP_W] == 8'hfe;

  // a stalled result holds
  `FRTI_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))
  // result exponent never exceeds the limit
  `FRTI_ASSERT_IMP(a_exp_range, clk, rst_n, out_tvalid, !exp_top && !exp_big)
  // a free output never blocks the input
  `FRTI_ASSERT_IMP(a_ready_flow, clk, rst_n, out_tready, in_tready)
  // an accepted operand moves on to the output register when the output is free
  `FRTI_ASSERT_NXT(a_latency, clk, rst_n, $past(in_xact) && out_tready, out_tvalid)

endmodule

bind float_reciprocal_table_interp_unit frti_checker u_frti_checker (.*);

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import frti_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned ITEMS_PER_PHASE = 238;
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct {
    logic [WORD_W-1:0] operand;
    logic [WORD_W-1:0] reciprocal;
  } recip_expect_t;

  class recip_scoreboard;
    recip_expect_t expected_recips[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // table lookup plus linear correction; exponent is 253 minus the operand exponent, or 0 above 253
    function logic [WORD_W-1:0] approx_reciprocal(logic [WORD_W-1:0] w);
      logic [63:0] a;
      logic [63:0] slope_full;
      logic [63:0] icept_full;
      logic [SLOPE_W-1:0] slope;
      logic [FRAC_W-1:0] icept;
      logic [FRAC_W-1:0] frac;
      logic [PROD_W-1:0] prod;
      logic [EXP_W-1:0] e;
      logic [EXP_W-1:0] ex;
      a = 64'd2048 + 64'(w[FRAC_W-1:LOW_W]);
      slope_full = (((2 * a + 1) * (2 * a + 1)) << 33) / (a * a * (a + 1) * (a + 1));
      icept_full = (((2 * a + 1) * (2 * a + 3)) << 33) / (a * (a + 1) * (a + 1));
      slope = slope_full[SLOPE_W-1:0];
      icept = icept_full[FRAC_W-1:0];
      prod = slope * w[LOW_W-1:0];
      frac = icept - FRAC_W'(prod[PROD_W-1:LOW_W]);
      e = w[WORD_W-2:FRAC_W];
      ex = (e > EXP_LIMIT) ? '0 : EXP_LIMIT - e;
      return {w[WORD_W-1], ex, frac};
    endfunction

    function void note_operand(logic [WORD_W-1:0] w);
      recip_expect_t x;
      x.operand = w;
      x.reciprocal = approx_reciprocal(w);
      expected_recips.push_back(x);
    endfunction

    function void check_reciprocal(logic [WORD_W-1:0] got);
      recip_expect_t x;
      if (expected_recips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      x = expected_recips.pop_front();
      if (got !== x.reciprocal) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch operand %h: expected %h got %h", x.operand, x.reciprocal, got);
      end
    endfunction

    function int unsigned pending();
      return expected_recips.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [WORD_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [WORD_W-1:0] out_tdata;

  recip_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  float_reciprocal_table_interp_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_operand(in_tdata);
      if (out_tvalid && out_tready) sb.check_reciprocal(out_tdata);
    end
  end

  task automatic send_operand(input logic [WORD_W-1:0] w);
    in_tdata <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [WORD_W-1:0] random_operand();
    logic [WORD_W-1:0] w;
    logic [EXP_W-1:0] edge_exps [6];
    edge_exps = '{8'd0, 8'd1, 8'd252, 8'd253, 8'd254, 8'd255};
    w = $urandom;
    if ($urandom_range(99) < 30) w[WORD_W-2:FRAC_W] = edge_exps[$urandom_range(5)];
    case ($urandom_range(9))
      0: w[LOW_W-1:0] = '0;
      1: w[LOW_W-1:0] = '1;
      2: w[FRAC_W-1:LOW_W] = '0;
      3: w[FRAC_W-1:LOW_W] = '1;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [WORD_W-1:0] directed_ops [$];
    int unsigned send_pcts [NUM_PHASES];
    int unsigned recv_pcts [NUM_PHASES];
    send_pcts = '{0, 47, 0, 35};
    recv_pcts = '{0, 0, 47, 35};
    directed_ops = {
      32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
      32'h7fc0_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001,
      32'h007f_ffff, 32'h3f80_0000, 32'hbf80_0000, 32'h3fff_ffff,
      32'h7e00_0000, 32'h7e80_0000, 32'h7f00_0000, 32'h7f7f_ffff,
      32'hfe80_0fff, 32'h3f80_0fff, 32'h3fff_f000, 32'h4000_0000,
      32'h0080_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h3f80_1000
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) send_operand(directed_ops[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // stall the output while the sender keeps pushing
        if (p == 0 && n == 20) long_hold_req = 1'b1;
        send_operand(random_operand());
      end
    end

    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
